// File: rtl/core/swrsi_pkg.sv
// Shared constants, types and state encoding for the sliding-window RSI block.
`default_nettype none
package swrsi_pkg;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned LEN_W      = PTR_W + 1;
  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned CHG_W      = PRICE_W + 1;
  localparam int unsigned SUM_W      = PRICE_W + PTR_W;
  localparam int unsigned RSI_W      = 23;
  localparam int unsigned CNT_W      = $clog2(RSI_W);

  localparam logic [RSI_W-1:0] RSI_SCALE  = RSI_W'(6553600);
  localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(14);
  localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(RING_DEPTH);
  localparam logic [LEN_W-1:0] LEN_MIN    = LEN_W'(1);

  typedef struct packed {
    logic                    re;
    logic [PTR_W-1:0]        raddr;
    logic                    we;
    logic [PTR_W-1:0]        waddr;
    logic signed [CHG_W-1:0] wdata;
  } ring_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_REMOVE,
    ST_ADD,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/core/swrsi_ring.sv
// Ring memory of price changes: one write port and one registered read port.
`default_nettype none
module swrsi_ring (
  input  wire logic                                       clk,
  input  wire swrsi_pkg::ring_req_t                       req,
  output logic signed [swrsi_pkg::CHG_W-1:0]              rdata
);

  logic signed [swrsi_pkg::CHG_W-1:0] mem [swrsi_pkg::RING_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/swrsi_div.sv
// Radix-2 restoring divider for floor(RSI_SCALE * gain / total), one scale bit per cycle.
`default_nettype none
module swrsi_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [swrsi_pkg::SUM_W-1:0]   gain,
  input  wire logic [swrsi_pkg::SUM_W-1:0]   total,
  output logic                               done,
  output logic [swrsi_pkg::RSI_W-1:0]        quotient
);

  localparam int unsigned RW = swrsi_pkg::SUM_W + 2;

  logic                          busy;
  logic [swrsi_pkg::CNT_W-1:0]   cnt;
  logic [swrsi_pkg::SUM_W-1:0]   rem;
  logic [swrsi_pkg::SUM_W-1:0]   g;
  logic [swrsi_pkg::SUM_W-1:0]   d;

  logic [RW-1:0]                 r2;
  logic [RW-1:0]                 d1;
  logic [RW-1:0]                 d2;
  logic [RW-1:0]                 r_sub;
  logic [1:0]                    digit;

  // Since gain <= total and rem < total, the shifted remainder stays below
  // three times the divisor, so each step yields a digit of 0, 1 or 2.
  always_comb begin
    d1 = {2'b00, d};
    d2 = {1'b0, d, 1'b0};
    r2 = {1'b0, rem, 1'b0} + (swrsi_pkg::RSI_SCALE[cnt] ? {2'b00, g} : '0);
    if (r2 >= d2) begin
      r_sub = r2 - d2;
      digit = 2'd2;
    end else if (r2 >= d1) begin
      r_sub = r2 - d1;
      digit = 2'd1;
    end else begin
      r_sub = r2;
      digit = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= swrsi_pkg::CNT_W'(swrsi_pkg::RSI_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      g        <= gain;
      d        <= total;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      rem      <= r_sub[swrsi_pkg::SUM_W-1:0];
      quotient <= {quotient[swrsi_pkg::RSI_W-2:0], 1'b0} + swrsi_pkg::RSI_W'(digit);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/sliding_window_rsi.sv
// Sliding-window RSI: sequencer, running sums and output register around ring and divider.
// A first price of a series is absorbed in its accept cycle. Any other word passes
// through the read, remove, add and check states to update the ring and sums, then the
// 23-step divider when a result needs a division, then the emit state loads the output register.
// The divider, when used, sets the pace; a new word is taken only in the idle state.
// Synchronous reset clears the series, sets window_length to 14 and empties the output;
// ring contents are not cleared, and a value read from the ring is used only after being written.
`default_nettype none
module sliding_window_rsi (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [swrsi_pkg::LEN_W-1:0]         cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [swrsi_pkg::PRICE_W-1:0]       close_price,
  input  wire logic                                start_of_series,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [swrsi_pkg::RSI_W-1:0]              rsi_value
);

  swrsi_pkg::state_t state, state_next;

  logic [swrsi_pkg::LEN_W-1:0]      window_length;
  logic [swrsi_pkg::PRICE_W-1:0]    previous_close;
  logic [swrsi_pkg::SUM_W-1:0]      gain_sum;
  logic [swrsi_pkg::SUM_W-1:0]      loss_sum;
  logic [swrsi_pkg::LEN_W-1:0]      changes_held;
  logic [swrsi_pkg::PTR_W-1:0]      ring_pointer;
  logic                             have_previous;
  logic signed [swrsi_pkg::CHG_W-1:0] change;
  logic                             full;
  logic [swrsi_pkg::SUM_W-1:0]      total;
  logic [swrsi_pkg::RSI_W-1:0]      result;

  logic [swrsi_pkg::LEN_W-1:0]      len;
  logic [swrsi_pkg::PTR_W-1:0]      old_index;
  logic                             in_accept;
  logic                             out_free;
  logic                             div_start;
  logic                             div_done;
  logic [swrsi_pkg::RSI_W-1:0]      quotient;
  logic signed [swrsi_pkg::CHG_W-1:0] old_change;
  logic signed [swrsi_pkg::CHG_W-1:0] old_neg;
  logic signed [swrsi_pkg::CHG_W-1:0] chg_neg;
  logic [swrsi_pkg::PRICE_W-1:0]    old_mag;
  logic [swrsi_pkg::PRICE_W-1:0]    chg_mag;
  swrsi_pkg::ring_req_t             ring_req;

  swrsi_ring u_ring (
    .clk   (clk),
    .req   (ring_req),
    .rdata (old_change)
  );

  swrsi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .gain     (gain_sum),
    .total    (total),
    .done     (div_done),
    .quotient (quotient)
  );

  // Zero acts as one and anything above the ring depth acts as the full ring.
  always_comb begin
    if (window_length == '0) begin
      len = swrsi_pkg::LEN_MIN;
    end else if (window_length > swrsi_pkg::LEN_MAX) begin
      len = swrsi_pkg::LEN_MAX;
    end else begin
      len = window_length;
    end
  end

  // The sums are final in the check state, where the divider loads them.
  assign total     = gain_sum + loss_sum;
  assign old_index = ring_pointer - len[swrsi_pkg::PTR_W-1:0];
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign old_neg   = -old_change;
  assign chg_neg   = -change;
  assign old_mag   = (old_change > 0) ? old_change[swrsi_pkg::PRICE_W-1:0]
                                      : old_neg[swrsi_pkg::PRICE_W-1:0];
  assign chg_mag   = (change > 0) ? change[swrsi_pkg::PRICE_W-1:0]
                                  : chg_neg[swrsi_pkg::PRICE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swrsi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    div_start      = 1'b0;
    ring_req.re    = 1'b0;
    ring_req.raddr = old_index;
    ring_req.we    = 1'b0;
    ring_req.waddr = ring_pointer;
    ring_req.wdata = change;
    case (state)
      swrsi_pkg::ST_IDLE: begin
        // No word is taken while reset is held.
        in_stall = rst;
        if (in_valid && have_previous && !start_of_series) begin
          state_next = swrsi_pkg::ST_READ;
        end
      end
      swrsi_pkg::ST_READ: begin
        ring_req.re = 1'b1;
        state_next  = swrsi_pkg::ST_REMOVE;
      end
      swrsi_pkg::ST_REMOVE: begin
        state_next = swrsi_pkg::ST_ADD;
      end
      swrsi_pkg::ST_ADD: begin
        ring_req.we = 1'b1;
        state_next  = swrsi_pkg::ST_CHECK;
      end
      swrsi_pkg::ST_CHECK: begin
        if (changes_held < len) begin
          state_next = swrsi_pkg::ST_IDLE;
        end else if (loss_sum == '0) begin
          state_next = swrsi_pkg::ST_EMIT;
        end else begin
          div_start  = 1'b1;
          state_next = swrsi_pkg::ST_DIV;
        end
      end
      swrsi_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = swrsi_pkg::ST_EMIT;
        end
      end
      swrsi_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = swrsi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swrsi_pkg::ST_IDLE;
      end
    endcase
  end

  // Series state and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= swrsi_pkg::LEN_RESET;
      previous_close <= '0;
      gain_sum       <= '0;
      loss_sum       <= '0;
      changes_held   <= '0;
      ring_pointer   <= '0;
      have_previous  <= 1'b0;
    end else begin
      case (state)
        swrsi_pkg::ST_IDLE: begin
          if (in_accept) begin
            previous_close <= close_price;
            have_previous  <= 1'b1;
            if (start_of_series || !have_previous) begin
              gain_sum     <= '0;
              loss_sum     <= '0;
              changes_held <= '0;
              ring_pointer <= '0;
            end
          end
        end
        swrsi_pkg::ST_REMOVE: begin
          if (full) begin
            if (old_change > 0) begin
              gain_sum <= gain_sum - swrsi_pkg::SUM_W'(old_mag);
            end else begin
              loss_sum <= loss_sum - swrsi_pkg::SUM_W'(old_mag);
            end
          end
        end
        swrsi_pkg::ST_ADD: begin
          if (change > 0) begin
            gain_sum <= gain_sum + swrsi_pkg::SUM_W'(chg_mag);
          end else begin
            loss_sum <= loss_sum + swrsi_pkg::SUM_W'(chg_mag);
          end
          if (!full) begin
            changes_held <= changes_held + 1'b1;
          end
          ring_pointer <= ring_pointer + 1'b1;
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        window_length  <= cfg_data;
        previous_close <= '0;
        gain_sum       <= '0;
        loss_sum       <= '0;
        changes_held   <= '0;
        ring_pointer   <= '0;
        have_previous  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == swrsi_pkg::ST_IDLE && in_accept) begin
      change <= swrsi_pkg::CHG_W'({1'b0, close_price}) - swrsi_pkg::CHG_W'({1'b0, previous_close});
    end
    if (state == swrsi_pkg::ST_READ) begin
      full <= (changes_held >= len);
    end
    if (state == swrsi_pkg::ST_CHECK) begin
      result <= swrsi_pkg::RSI_SCALE;
    end
    if (state == swrsi_pkg::ST_DIV && div_done) begin
      result <= quotient;
    end
  end

  // Output register; the next word may be taken while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == swrsi_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == swrsi_pkg::ST_EMIT && out_free) begin
      rsi_value <= result;
    end
  end

endmodule
`default_nettype wire
